@@ hw/rtl/ssl_pkg.sv @@
// Shared types and constants for the script source lexer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ssl_pkg;

    localparam int POS_W   = 24;
    localparam int LINE_W  = 16;
    localparam int LEN_W   = 16;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [2:0]
    {
        MODE_IDLE,
        MODE_INT,
        MODE_IDENT,
        MODE_STR,
        MODE_ESC,
        MODE_COMMENT
    } mode_t;

    localparam logic [1:0] RK_TOKEN = 2'd0;
    localparam logic [1:0] RK_ERROR = 2'd1;
    localparam logic [1:0] RK_DONE  = 2'd2;

    localparam logic [3:0] TK_INT     = 4'd0;
    localparam logic [3:0] TK_IDENT   = 4'd1;
    localparam logic [3:0] TK_STRING  = 4'd2;
    localparam logic [3:0] TK_COMMENT = 4'd3;
    localparam logic [3:0] TK_COLON   = 4'd4;
    localparam logic [3:0] TK_SEMI    = 4'd5;
    localparam logic [3:0] TK_DOT     = 4'd6;
    localparam logic [3:0] TK_TILDE   = 4'd7;
    localparam logic [3:0] TK_ADD     = 4'd8;
    localparam logic [3:0] TK_SUB     = 4'd9;
    localparam logic [3:0] TK_MUL     = 4'd10;
    localparam logic [3:0] TK_DIV     = 4'd11;
    localparam logic [3:0] TK_LT      = 4'd12;
    localparam logic [3:0] TK_GT      = 4'd13;

    localparam logic EC_UNEXPECTED   = 1'b0;
    localparam logic EC_UNTERMINATED = 1'b1;

    typedef struct packed
    {
        logic [7:0] source_byte;
        logic       end_of_source;
    } src_item_t;

    typedef struct packed
    {
        logic [1:0]        result_kind;
        logic [3:0]        token_kind;
        logic [POS_W-1:0]  start_position;
        logic [LINE_W-1:0] start_line;
        logic [LINE_W-1:0] start_column;
        logic [LEN_W-1:0]  token_length;
        logic              error_code;
        logic              last_of_run;
    } tok_item_t;

    // Up to two results from one source item, in order
    typedef struct packed
    {
        logic [1:0] count;
        tok_item_t  first;
        tok_item_t  second;
    } res_push_t;

endpackage

@@ hw/rtl/ssl_core.sv @@
// Lexer state, counters and per-byte decode; yields up to two results a byte.
// Depends on ssl_pkg.
`timescale 1ns / 1ps

module ssl_core
    import ssl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      go,
    input  src_item_t item,
    output res_push_t push
);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_US    = 8'h5F;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_NUL   = 8'h00;

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        // bit 4 set when c is a punctuation byte
        logic [4:0] r;
        unique case (c)
            8'h3A:   r = {1'b1, TK_COLON};
            8'h3B:   r = {1'b1, TK_SEMI};
            8'h2E:   r = {1'b1, TK_DOT};
            8'h7E:   r = {1'b1, TK_TILDE};
            8'h2B:   r = {1'b1, TK_ADD};
            8'h2D:   r = {1'b1, TK_SUB};
            8'h2A:   r = {1'b1, TK_MUL};
            8'h2F:   r = {1'b1, TK_DIV};
            8'h3C:   r = {1'b1, TK_LT};
            8'h3E:   r = {1'b1, TK_GT};
            default: r = {1'b0, TK_INT};
        endcase
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] len_sat(input logic [POS_W:0] v);
        logic [LEN_W-1:0] r;
        if (|v[POS_W:LEN_W])
            r = '1;
        else
            r = v[LEN_W-1:0];
        return r;
    endfunction

    mode_t             mode_reg, mode_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [LINE_W-1:0] col_reg, col_next;
    logic [POS_W-1:0]  tpos_reg, tpos_next;
    logic [LINE_W-1:0] tline_reg, tline_next;
    logic [LINE_W-1:0] tcol_reg, tcol_next;
    logic              halted_reg, halted_next;

    logic [7:0] c;
    logic       is_end, is_digit, is_lead, is_body, is_white, is_punct;
    logic [4:0] pk;
    logic       relex, pend_emit, idle_emit, advance;
    logic [POS_W-1:0] span;
    tok_item_t  slot_a, slot_b;
    logic       a_v, b_v;

    assign c        = item.source_byte;
    assign is_end   = item.end_of_source || (c == CH_NUL);
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign is_lead  = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
                      || (c == CH_US);
    assign is_body  = is_lead || is_digit;
    assign is_white = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
    assign pk       = punct_kind(c);
    assign is_punct = pk[4];
    assign span     = pos_reg - tpos_reg;
    assign advance  = go && !is_end && !halted_reg;

    // the byte that ends an int or ident is lexed afresh in the same step
    assign relex = !is_end && !halted_reg &&
                   ((mode_reg == MODE_IDLE) ||
                    ((mode_reg == MODE_INT) && !is_digit) ||
                    ((mode_reg == MODE_IDENT) && !is_body));

    assign idle_emit = relex && !is_white && !is_digit && !is_lead
                       && (c != CH_QUOTE) && (c != CH_HASH);

    always_comb
    begin
        pend_emit = 1'b0;
        if (!halted_reg)
        begin
            if (is_end)
                pend_emit = (mode_reg != MODE_IDLE);
            else
            begin
                unique case (mode_reg)
                    MODE_INT:     pend_emit = !is_digit;
                    MODE_IDENT:   pend_emit = !is_body;
                    MODE_STR:     pend_emit = (c == CH_QUOTE);
                    MODE_COMMENT: pend_emit = (c == CH_NL);
                    default:      pend_emit = 1'b0;
                endcase
            end
        end
    end

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        tpos_next   = tpos_reg;
        tline_next  = tline_reg;
        tcol_next   = tcol_reg;
        halted_next = halted_reg;
        if (go)
        begin
            if (is_end)
            begin
                mode_next   = MODE_IDLE;
                pos_next    = '0;
                line_next   = '0;
                col_next    = '0;
                tpos_next   = '0;
                tline_next  = '0;
                tcol_next   = '0;
                halted_next = 1'b0;
            end
            else if (!halted_reg)
            begin
                unique case (mode_reg)
                    MODE_STR:
                    begin
                        if (c == CH_QUOTE)
                            mode_next = MODE_IDLE;
                        else if (c == CH_BSL)
                            mode_next = MODE_ESC;
                    end
                    MODE_ESC:     mode_next = MODE_STR;
                    MODE_COMMENT:
                    begin
                        if (c == CH_NL)
                            mode_next = MODE_IDLE;
                    end
                    default:      mode_next = mode_reg;
                endcase
                if (relex)
                begin
                    mode_next = MODE_IDLE;
                    if (!is_white)
                    begin
                        tpos_next  = pos_reg;
                        tline_next = line_reg;
                        tcol_next  = col_reg;
                        if (is_digit)
                            mode_next = MODE_INT;
                        else if (is_lead)
                            mode_next = MODE_IDENT;
                        else if (c == CH_QUOTE)
                            mode_next = MODE_STR;
                        else if (c == CH_HASH)
                            mode_next = MODE_COMMENT;
                        else if (!is_punct)
                            halted_next = 1'b1;
                    end
                end
                if (advance)
                begin
                    if (!(&pos_reg))
                        pos_next = pos_reg + 1'b1;
                    if (c == CH_NL)
                    begin
                        if (!(&line_reg))
                            line_next = line_reg + 1'b1;
                        col_next = '0;
                    end
                    else if (!(&col_reg))
                        col_next = col_reg + 1'b1;
                end
            end
        end
    end

    // results: slot A flushes the pending token, slot B is the fresh byte or done
    always_comb
    begin
        slot_a = '0;
        slot_b = '0;
        slot_a.start_position = tpos_reg;
        slot_a.start_line     = tline_reg;
        slot_a.start_column   = tcol_reg;
        slot_a.token_length   = len_sat({1'b0, span});
        slot_b.start_position = pos_reg;
        slot_b.start_line     = line_reg;
        slot_b.start_column   = col_reg;
        a_v = go && pend_emit;
        b_v = go && (is_end || idle_emit);

        unique case (mode_reg)
            MODE_INT:     slot_a.token_kind = TK_INT;
            MODE_IDENT:   slot_a.token_kind = TK_IDENT;
            MODE_COMMENT: slot_a.token_kind = TK_COMMENT;
            MODE_STR, MODE_ESC:
            begin
                if (is_end)
                begin
                    slot_a.result_kind = RK_ERROR;
                    slot_a.error_code  = EC_UNTERMINATED;
                end
                else
                begin
                    slot_a.token_kind   = TK_STRING;
                    slot_a.token_length = len_sat({1'b0, span} + 1'b1);
                end
            end
            default:      slot_a.token_kind = TK_INT;
        endcase

        if (is_end)
            slot_b.result_kind = RK_DONE;
        else if (is_punct)
        begin
            slot_b.token_kind   = pk[3:0];
            slot_b.token_length = {{(LEN_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            slot_b.result_kind = RK_ERROR;
            slot_b.error_code  = EC_UNEXPECTED;
        end

        slot_a.last_of_run = !b_v;
        slot_b.last_of_run = 1'b1;

        push.count  = {1'b0, a_v} + {1'b0, b_v};
        push.first  = a_v ? slot_a : slot_b;
        push.second = slot_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            line_reg   <= '0;
            col_reg    <= '0;
            tpos_reg   <= '0;
            tline_reg  <= '0;
            tcol_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            tpos_reg   <= tpos_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
            halted_reg <= halted_next;
        end
    end

endmodule

@@ hw/rtl/ssl_result_queue.sv @@
// Small result queue: takes up to two results a cycle, hands out one while tok_ready is high.
// Depends on ssl_pkg.
`timescale 1ns / 1ps

module ssl_result_queue
    import ssl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  res_push_t         push,
    output logic [QCNT_W-1:0] fill,
    output logic              tok_valid,
    input  logic              tok_ready,
    output tok_item_t         tok_item
);

    tok_item_t         entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [QPTR_W-1:0] wr_plus1;
    logic              pop;

    assign wr_plus1  = wr_reg + 1'b1;
    assign pop       = tok_valid && tok_ready;
    assign tok_valid = (cnt_reg != '0);
    assign tok_item  = entry_reg[rd_reg];
    assign fill      = cnt_reg;

    always_comb
    begin
        wr_next  = wr_reg + QPTR_W'(push.count);
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_plus1] <= push.second;
    end

endmodule

@@ hw/rtl/script_source_lexer.sv @@
// Script source lexer: byte stream in, token results out.
// With the queue empty, a byte's first result is offered once the byte has passed the
// input register and the queue. A byte is taken each cycle while the 4-entry queue has
// room for the two results (token end plus punctuation or error) one byte can give.
// Reset clears mode, counters and queue; done clears mode and counters, not the queue.
// Depends on ssl_pkg, ssl_core, ssl_result_queue.
`timescale 1ns / 1ps

module script_source_lexer
    import ssl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  src_item_t src_item,
    output logic      tok_valid,
    input  logic      tok_ready,
    output tok_item_t tok_item
);

    src_item_t         src_reg;
    logic              src_valid_reg, src_valid_next;
    logic              core_go;
    logic [QCNT_W-1:0] fill;
    res_push_t         push;

    // room for the worst case of two results
    assign core_go   = src_valid_reg && (fill <= QCNT_W'(QDEPTH - 2));
    assign src_ready = !src_valid_reg || core_go;

    always_comb
    begin
        if (src_valid && src_ready)
            src_valid_next = 1'b1;
        else if (core_go)
            src_valid_next = 1'b0;
        else
            src_valid_next = src_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            src_valid_reg <= 1'b0;
        else
            src_valid_reg <= src_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
            src_reg <= src_item;
    end

    ssl_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (core_go),
        .item  (src_reg),
        .push  (push)
    );

    ssl_result_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .fill      (fill),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_item  (tok_item)
    );

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (push.second.last_of_run && !push.first.last_of_run))
        else $error("last_of_run misplaced on a result pair");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd1) |-> push.first.last_of_run)
        else $error("single result without last_of_run");

    a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !core_go |-> (push.count == 2'd0))
        else $error("results pushed without a source item");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid_reg && !core_go) |=> src_valid_reg)
        else $error("held source item dropped");

endmodule
